@@ rtl/core/ugnb_pkg.sv @@
// shared types, constants and helper functions for the uniform grid neighbour binning block
// no dependencies; compiled before the interfaces and modules

package ugnb_pkg;

    // sizing of the grid and its stores
    localparam int MAX_PARTICLES      = 4096;
    localparam int CELL_CAPACITY      = 16;
    localparam int MAX_CELLS_PER_AXIS = 16;

    localparam int COORD_W   = $clog2(MAX_CELLS_PER_AXIS);
    localparam int NAX_W     = $clog2(MAX_CELLS_PER_AXIS + 1);
    localparam int CELL_W    = 3 * COORD_W;
    localparam int NUM_CELLS = MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS;
    localparam int PID_W     = $clog2(MAX_PARTICLES);
    localparam int CAP_W     = $clog2(CELL_CAPACITY);
    localparam int CNT_W     = $clog2(CELL_CAPACITY + 1);
    localparam int MEM_AW    = CELL_W + CAP_W;
    localparam int PCELL_W   = CELL_W + 1;
    localparam int SWEEP_W   = (CELL_W > PID_W) ? CELL_W : PID_W;

    // field widths
    localparam int KIND_W = 2;
    localparam int ID_W   = 12;
    localparam int POS_W  = 16;
    localparam int SLOT_W = 5;
    localparam int STAT_W = 2;
    localparam int INV_W  = 16;
    localparam int NREG_W = 5;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 3;
    localparam int FRAC_W = 8;

    // derived arithmetic widths for the binning multiply
    localparam int DIFF_W  = POS_W + 1;
    localparam int PROD_W  = DIFF_W + INV_W + 1;
    localparam int WHOLE_W = PROD_W - FRAC_W * 2;

    localparam logic [SWEEP_W-1:0] SWEEP_LAST = SWEEP_W'((1 << SWEEP_W) - 1);
    localparam logic [SWEEP_W-1:0] CELL_LAST  = SWEEP_W'(NUM_CELLS - 1);
    localparam logic [SLOT_W-1:0]  SLOT_MAX   = SLOT_W'(26);
    localparam logic [CNT_W-1:0]   CAP_CNT    = CNT_W'(CELL_CAPACITY);

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OUTSIDE  = 2'd1,
        ST_FULL     = 2'd2,
        ST_NBR_OUT  = 2'd3
    } t_status;

    // configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_INV_CELL = 3'd3,
        CFG_CELLS_X  = 3'd4,
        CFG_CELLS_Y  = 3'd5,
        CFG_CELLS_Z  = 3'd6
    } t_cfg_idx;

    // controller states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_BIN,
        S_INS,
        S_QRY,
        S_QCNT,
        S_QMEM,
        S_EMIT
    } t_state;

    // input item payload
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [ID_W-1:0]         particle_id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [SLOT_W-1:0]       neighbor_slot;
    } t_in_item;

    // result item payload
    typedef struct packed {
        logic [ID_W-1:0]   neighbor_id;
        logic              found;
        logic              last;
        logic [STAT_W-1:0] status;
    } t_out_item;

    // per-axis lane finding
    typedef struct packed {
        logic               outside;
        logic [COORD_W-1:0] coord;
    } t_axis_res;

    // neighbour offsets, each shifted by one
    typedef struct packed {
        logic [1:0] dz;
        logic [1:0] dy;
        logic [1:0] dx;
    } t_slot_d;

    // clamp a cell-count register to the supported range
    function automatic logic [NAX_W-1:0] axis_cells(input logic [NREG_W-1:0] r);
        logic [NAX_W-1:0] n;
        if (r == '0) begin
            n = NAX_W'(1);
        end else if (r > NREG_W'(MAX_CELLS_PER_AXIS)) begin
            n = NAX_W'(MAX_CELLS_PER_AXIS);
        end else begin
            n = NAX_W'(r);
        end
        return n;
    endfunction

    // split a slot number into base-three digits by compare and subtract
    function automatic t_slot_d slot_offsets(input logic [SLOT_W-1:0] slot);
        t_slot_d          d;
        logic [SLOT_W-1:0] r;
        if (slot >= SLOT_W'(18)) begin
            d.dz = 2'd2;
            r    = slot - SLOT_W'(18);
        end else if (slot >= SLOT_W'(9)) begin
            d.dz = 2'd1;
            r    = slot - SLOT_W'(9);
        end else begin
            d.dz = 2'd0;
            r    = slot;
        end
        if (r >= SLOT_W'(6)) begin
            d.dy = 2'd2;
            r    = r - SLOT_W'(6);
        end else if (r >= SLOT_W'(3)) begin
            d.dy = 2'd1;
            r    = r - SLOT_W'(3);
        end else begin
            d.dy = 2'd0;
        end
        d.dx = r[1:0];
        return d;
    endfunction

endpackage

@@ rtl/core/ugnb_in_if.sv @@
// valid/ready channel carrying one input item
// depends on ugnb_pkg

interface ugnb_in_if import ugnb_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/ugnb_out_if.sv @@
// valid/ready channel carrying one result item
// depends on ugnb_pkg

interface ugnb_out_if import ugnb_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/ugnb_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies

module ugnb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/ugnb_axis_lane.sv @@
// one axis lane: bins a position into a cell coordinate and offsets a stored coordinate
// depends on ugnb_pkg

module ugnb_axis_lane import ugnb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_load,
    input  logic signed [POS_W-1:0] i_pos,
    input  logic signed [POS_W-1:0] i_org,
    input  logic [INV_W-1:0]        i_inv,
    input  logic [NAX_W-1:0]        i_ncell,
    input  logic [COORD_W-1:0]      i_coord,
    input  logic [1:0]              i_delta,
    output t_axis_res               o_bin,
    output t_axis_res               o_nbr
);

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] r_prod;
    logic [WHOLE_W-1:0]       whole;
    logic [COORD_W:0]         p;
    logic [COORD_W:0]         pm1;

    // exact offset from the grid origin
    assign diff = DIFF_W'(i_pos) - DIFF_W'(i_org);

    // scaled offset, registered before the range check
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= diff * $signed({1'b0, i_inv});
        end
    end

    // integer part of the scaled offset gives the cell
    assign whole         = r_prod[PROD_W-1:FRAC_W*2];
    assign o_bin.outside = r_prod[PROD_W-1] || (whole >= WHOLE_W'(i_ncell));
    assign o_bin.coord   = whole[COORD_W-1:0];

    // neighbour coordinate: stored coordinate plus shifted offset, minus one
    assign p             = {1'b0, i_coord} + (COORD_W+1)'(i_delta);
    assign pm1           = p - (COORD_W+1)'(1);
    assign o_nbr.outside = (p == '0) || (pm1 >= (COORD_W+1)'(i_ncell));
    assign o_nbr.coord   = pm1[COORD_W-1:0];

endmodule

@@ rtl/core/uniform_grid_neighbor_binning.sv @@
// uniform 3d cell grid for neighbour search: controller, merge of axis lanes, stores
// depends on ugnb_pkg, ugnb_in_if, ugnb_out_if, ugnb_ram, ugnb_axis_lane
//
// Usage
//   i_item carries clear, insert and query items; o_res returns results, each a
//   transfer with a valid/ready handshake. Configuration is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only while the
//   block is idle, which the block itself does not enforce.
//   After reset the block sweeps its cell-count and particle stores, one entry
//   a cycle, before it accepts the first item.
//   A clear item sweeps the cell-count store, then gives one result.
//   An insert gives its single result after these steps: the three axis
//   multiplies are registered, the count is read, the count is updated, then
//   the output register is loaded.
//   A query gives one stored id a cycle while the receiver takes them; the
//   member store's single read port sets that rate.
//   Items are handled one at a time. A result sits in an output register, so
//   the next item is taken while it waits; a stalled receiver holds the block
//   in the step that gives a result, with nothing lost or repeated.

module uniform_grid_neighbor_binning import ugnb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ugnb_in_if.sink            i_item,
    ugnb_out_if.source         o_res,
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    // configuration registers
    logic signed [POS_W-1:0] r_org_x, r_org_y, r_org_z;
    logic [INV_W-1:0]        r_inv;
    logic [NREG_W-1:0]       r_ncx, r_ncy, r_ncz;

    // control and item registers
    t_state             r_state, n_state;
    logic [SWEEP_W-1:0] r_sweep, n_sweep;
    logic [PID_W-1:0]   r_pid, n_pid;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [CELL_W-1:0]  r_cell, n_cell;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CAP_W-1:0]   r_k, n_k;
    t_out_item          r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    // store ports
    logic               c_we;
    logic [CELL_W-1:0]  c_waddr, c_raddr;
    logic [CNT_W-1:0]   c_wdata, c_rdata;
    logic               p_we;
    logic [PID_W-1:0]   p_waddr, p_raddr;
    logic [PCELL_W-1:0] p_wdata, p_rdata;
    logic               m_we;
    logic [MEM_AW-1:0]  m_waddr, m_raddr;
    logic [ID_W-1:0]    m_wdata, m_rdata;

    // lane signals
    logic             accept;
    logic             out_free;
    logic             push;
    t_out_item        push_item;
    t_slot_d          dsl;
    t_axis_res        bin_x, bin_y, bin_z;
    t_axis_res        nbr_x, nbr_y, nbr_z;
    logic             bin_out, nbr_out;
    logic [CELL_W-1:0] bin_cell, nbr_cell;
    logic [CNT_W-1:0] cnt_clip;
    logic             q_last;

    assign accept   = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign dsl      = slot_offsets(r_slot);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_inv   <= INV_W'(256);
            r_ncx   <= NREG_W'(MAX_CELLS_PER_AXIS);
            r_ncy   <= NREG_W'(MAX_CELLS_PER_AXIS);
            r_ncz   <= NREG_W'(MAX_CELLS_PER_AXIS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                CFG_ORIGIN_Z: r_org_z <= i_cfg_data;
                CFG_INV_CELL: r_inv   <= i_cfg_data;
                CFG_CELLS_X:  r_ncx   <= i_cfg_data[NREG_W-1:0];
                CFG_CELLS_Y:  r_ncy   <= i_cfg_data[NREG_W-1:0];
                CFG_CELLS_Z:  r_ncz   <= i_cfg_data[NREG_W-1:0];
                default: ;
            endcase
        end
    end

    // axis lanes
    ugnb_axis_lane u_lane_x (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_pos   (i_item.data.pos_x),
        .i_org   (r_org_x),
        .i_inv   (r_inv),
        .i_ncell (axis_cells(r_ncx)),
        .i_coord (p_rdata[COORD_W-1:0]),
        .i_delta (dsl.dx),
        .o_bin   (bin_x),
        .o_nbr   (nbr_x)
    );

    ugnb_axis_lane u_lane_y (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_pos   (i_item.data.pos_y),
        .i_org   (r_org_y),
        .i_inv   (r_inv),
        .i_ncell (axis_cells(r_ncy)),
        .i_coord (p_rdata[2*COORD_W-1:COORD_W]),
        .i_delta (dsl.dy),
        .o_bin   (bin_y),
        .o_nbr   (nbr_y)
    );

    ugnb_axis_lane u_lane_z (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_pos   (i_item.data.pos_z),
        .i_org   (r_org_z),
        .i_inv   (r_inv),
        .i_ncell (axis_cells(r_ncz)),
        .i_coord (p_rdata[3*COORD_W-1:2*COORD_W]),
        .i_delta (dsl.dz),
        .o_bin   (bin_z),
        .o_nbr   (nbr_z)
    );

    // merge lane findings into a cell index
    assign bin_out  = bin_x.outside || bin_y.outside || bin_z.outside;
    assign nbr_out  = nbr_x.outside || nbr_y.outside || nbr_z.outside;
    assign bin_cell = {bin_z.coord, bin_y.coord, bin_x.coord};
    assign nbr_cell = {nbr_z.coord, nbr_y.coord, nbr_x.coord};

    assign cnt_clip = (c_rdata > CAP_CNT) ? CAP_CNT : c_rdata;
    assign q_last   = ((CNT_W'(r_k) + CNT_W'(1)) == r_cnt);

    // stores
    ugnb_ram #(.WIDTH(CNT_W), .DEPTH(NUM_CELLS)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    ugnb_ram #(.WIDTH(PCELL_W), .DEPTH(MAX_PARTICLES)) u_pcell_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    ugnb_ram #(.WIDTH(ID_W), .DEPTH(NUM_CELLS * CELL_CAPACITY)) u_member_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    // read addresses
    assign c_raddr = (r_state == S_QRY) ? nbr_cell : bin_cell;
    assign p_raddr = i_item.data.particle_id[PID_W-1:0];
    assign m_raddr = {r_cell, n_k};

    assign i_item.ready = (r_state == S_IDLE);

    // controller: next state, store writes and result selection
    always_comb begin
        n_state   = r_state;
        n_sweep   = r_sweep;
        n_pid     = r_pid;
        n_slot    = r_slot;
        n_cell    = r_cell;
        n_cnt     = r_cnt;
        n_k       = r_k;
        n_res     = r_res;
        push      = 1'b0;
        push_item = r_res;
        c_we      = 1'b0;
        c_waddr   = r_sweep[CELL_W-1:0];
        c_wdata   = '0;
        p_we      = 1'b0;
        p_waddr   = r_sweep[PID_W-1:0];
        p_wdata   = '0;
        m_we      = 1'b0;
        m_waddr   = {r_cell, c_rdata[CAP_W-1:0]};
        m_wdata   = ID_W'(r_pid);

        unique case (r_state)
            // clear both stores after reset
            S_INIT: begin
                c_we    = 1'b1;
                p_we    = 1'b1;
                n_sweep = r_sweep + SWEEP_W'(1);
                if (r_sweep == SWEEP_LAST) begin
                    n_sweep = '0;
                    n_state = S_IDLE;
                end
            end

            // take an item
            S_IDLE: begin
                if (accept) begin
                    n_pid   = i_item.data.particle_id[PID_W-1:0];
                    n_slot  = i_item.data.neighbor_slot;
                    n_sweep = '0;
                    unique case (i_item.data.kind)
                        KIND_CLEAR:  n_state = S_CLEAR;
                        KIND_INSERT: n_state = S_BIN;
                        KIND_QUERY:  n_state = S_QRY;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end

            // empty every cell
            S_CLEAR: begin
                c_we    = 1'b1;
                n_sweep = r_sweep + SWEEP_W'(1);
                if (r_sweep == CELL_LAST) begin
                    n_sweep = '0;
                    n_res   = '{neighbor_id: '0, found: 1'b0, last: 1'b1, status: ST_OK};
                    n_state = S_EMIT;
                end
            end

            // lanes have binned the position
            S_BIN: begin
                p_we    = 1'b1;
                p_waddr = r_pid;
                if (bin_out) begin
                    p_wdata = '0;
                    n_res   = '{neighbor_id: ID_W'(r_pid), found: 1'b0, last: 1'b1,
                                status: ST_OUTSIDE};
                    n_state = S_EMIT;
                end else begin
                    p_wdata = {1'b1, bin_cell};
                    n_cell  = bin_cell;
                    n_state = S_INS;
                end
            end

            // append the id if the cell has room
            S_INS: begin
                if (c_rdata >= CAP_CNT) begin
                    n_res = '{neighbor_id: ID_W'(r_pid), found: 1'b0, last: 1'b1,
                              status: ST_FULL};
                end else begin
                    m_we    = 1'b1;
                    c_we    = 1'b1;
                    c_waddr = r_cell;
                    c_wdata = c_rdata + CNT_W'(1);
                    n_res   = '{neighbor_id: ID_W'(r_pid), found: 1'b0, last: 1'b1,
                                status: ST_OK};
                end
                n_state = S_EMIT;
            end

            // remembered cell is read; work out the neighbour cell
            S_QRY: begin
                if (!p_rdata[PCELL_W-1]) begin
                    n_res   = '{neighbor_id: '0, found: 1'b0, last: 1'b1, status: ST_OUTSIDE};
                    n_state = S_EMIT;
                end else if (r_slot > SLOT_MAX || nbr_out) begin
                    n_res   = '{neighbor_id: '0, found: 1'b0, last: 1'b1, status: ST_NBR_OUT};
                    n_state = S_EMIT;
                end else begin
                    n_cell  = nbr_cell;
                    n_state = S_QCNT;
                end
            end

            // neighbour cell count is read
            S_QCNT: begin
                n_k = '0;
                if (cnt_clip == '0) begin
                    n_res   = '{neighbor_id: '0, found: 1'b0, last: 1'b1, status: ST_OK};
                    n_state = S_EMIT;
                end else begin
                    n_cnt   = cnt_clip;
                    n_state = S_QMEM;
                end
            end

            // one stored id per transfer
            S_QMEM: begin
                push_item = '{neighbor_id: m_rdata, found: 1'b1, last: q_last, status: ST_OK};
                if (out_free) begin
                    push = 1'b1;
                    if (q_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + CAP_W'(1);
                    end
                end
            end

            // single result
            S_EMIT: begin
                if (out_free) begin
                    push    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = push || (r_out_valid && !o_res.ready);
        n_out       = push ? push_item : r_out;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        r_pid  <= n_pid;
        r_slot <= n_slot;
        r_cell <= n_cell;
        r_cnt  <= n_cnt;
        r_k    <= n_k;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

@@ verif/uniform_grid_neighbor_binning_tb.sv @@
// testbench for the uniform grid neighbour binning block: a cell-list predictor checks every result
// depends on ugnb_pkg, ugnb_in_if, ugnb_out_if and the uniform_grid_neighbor_binning top level

module uniform_grid_neighbor_binning_tb import ugnb_pkg::*; ;

    // cell-list predictor and the queue of results it expects
    class cell_list_model;
        bit signed [POS_W-1:0] org [3];
        bit [INV_W-1:0]        inv;
        bit [NREG_W-1:0]       nreg [3];
        bit [CNT_W-1:0]        cnt [NUM_CELLS];
        bit [ID_W-1:0]         members [NUM_CELLS][CELL_CAPACITY];
        bit [COORD_W-1:0]      pcell [MAX_PARTICLES][3];
        bit                    pvalid [MAX_PARTICLES];
        t_out_item             pending_results[$];
        int                    errors;
        int                    checked;
        int                    found_seen;
        int                    status_seen [4];

        function new();
            foreach (org[i]) begin
                org[i]  = '0;
                nreg[i] = NREG_W'(MAX_CELLS_PER_AXIS);
            end
            inv = INV_W'(256);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_ORIGIN_X: org[0] = v;
                CFG_ORIGIN_Y: org[1] = v;
                CFG_ORIGIN_Z: org[2] = v;
                CFG_INV_CELL: inv = v;
                CFG_CELLS_X:  nreg[0] = v[NREG_W-1:0];
                CFG_CELLS_Y:  nreg[1] = v[NREG_W-1:0];
                CFG_CELLS_Z:  nreg[2] = v[NREG_W-1:0];
                default: ;
            endcase
        endfunction

        // effective number of cells on one axis
        function int axis_n(int a);
            if (nreg[a] == 0) begin
                return 1;
            end
            if (nreg[a] > MAX_CELLS_PER_AXIS) begin
                return MAX_CELLS_PER_AXIS;
            end
            return int'(nreg[a]);
        endfunction

        // exact q16.16 product, integer part is the cell coordinate
        function bit axis_cell(int a, logic signed [POS_W-1:0] pos, output int c);
            longint diff;
            longint prod;
            diff = longint'(pos) - longint'(org[a]);
            prod = diff * longint'(inv);
            c = 0;
            if (prod < 0) begin
                return 1'b0;
            end
            c = int'(prod >>> 16);
            return (c < axis_n(a));
        endfunction

        function void expect_one(int id, t_status st);
            t_out_item r;
            r.neighbor_id = ID_W'(id);
            r.found       = 1'b0;
            r.last        = 1'b1;
            r.status      = st;
            pending_results.insert(pending_results.size(), r);
        endfunction

        // advance the predicted state by one accepted item
        function void note_item(t_in_item it);
            int        c [3];
            int        d [3];
            int        pid;
            int        slot;
            int        cidx;
            int        n;
            int        p;
            bit        ok;
            t_out_item r;
            pid  = int'(it.particle_id) % MAX_PARTICLES;
            slot = int'(it.neighbor_slot);
            case (t_kind'(it.kind))
                KIND_CLEAR: begin
                    foreach (cnt[i]) cnt[i] = '0;
                    expect_one(0, ST_OK);
                end
                KIND_INSERT: begin
                    ok = axis_cell(0, it.pos_x, c[0]);
                    if (ok) ok = axis_cell(1, it.pos_y, c[1]);
                    if (ok) ok = axis_cell(2, it.pos_z, c[2]);
                    if (!ok) begin
                        pvalid[pid] = 1'b0;
                        expect_one(pid, ST_OUTSIDE);
                    end else begin
                        for (int i = 0; i < 3; i++) pcell[pid][i] = COORD_W'(c[i]);
                        pvalid[pid] = 1'b1;
                        cidx = c[0] + MAX_CELLS_PER_AXIS * (c[1] + MAX_CELLS_PER_AXIS * c[2]);
                        if (cnt[cidx] >= CELL_CAPACITY) begin
                            expect_one(pid, ST_FULL);
                        end else begin
                            members[cidx][cnt[cidx]] = ID_W'(pid);
                            cnt[cidx]++;
                            expect_one(pid, ST_OK);
                        end
                    end
                end
                KIND_QUERY: begin
                    if (!pvalid[pid]) begin
                        expect_one(0, ST_OUTSIDE);
                    end else if (slot > int'(SLOT_MAX)) begin
                        expect_one(0, ST_NBR_OUT);
                    end else begin
                        d[0] = slot % 3;
                        d[1] = (slot / 3) % 3;
                        d[2] = slot / 9;
                        ok = 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            p = int'(pcell[pid][i]) + d[i];
                            if (p < 1 || p - 1 >= axis_n(i)) ok = 1'b0;
                            else c[i] = p - 1;
                        end
                        if (!ok) begin
                            expect_one(0, ST_NBR_OUT);
                        end else begin
                            cidx = c[0] + MAX_CELLS_PER_AXIS * (c[1] + MAX_CELLS_PER_AXIS * c[2]);
                            n = int'(cnt[cidx]);
                            if (n > CELL_CAPACITY) n = CELL_CAPACITY;
                            if (n == 0) begin
                                expect_one(0, ST_OK);
                            end
                            for (int k = 0; k < n; k++) begin
                                r.neighbor_id = members[cidx][k];
                                r.found       = 1'b1;
                                r.last        = (k == n - 1);
                                r.status      = ST_OK;
                                pending_results.insert(pending_results.size(), r);
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        // compare one result transfer with the oldest expectation
        task check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result id %0d found %0b last %0b status %0d",
                    got.neighbor_id, got.found, got.last, got.status));
                return;
            end
            want = pending_results.pop_front();
            checked++;
            status_seen[got.status]++;
            if (got.found) found_seen++;
            if (got.neighbor_id !== want.neighbor_id || got.found !== want.found ||
                got.last !== want.last || got.status !== want.status) begin
                report_mismatch($sformatf("result %0d: got id %0d f %0b l %0b s %0d, want id %0d f %0b l %0b s %0d",
                    checked, got.neighbor_id, got.found, got.last, got.status,
                    want.neighbor_id, want.found, want.last, want.status));
            end
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;

    ugnb_in_if  item_if ();
    ugnb_out_if res_if ();

    cell_list_model model;
    int             burst_left;
    int             items_sent;
    int             settings_run;
    int             known_ids[$];
    int             stall_mode;
    int             stall_timer;

    uniform_grid_neighbor_binning dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // receiver stalls in one of four modes, which a random timer changes
    always @(posedge i_clk) begin
        if (stall_timer == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(16, 96);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= 1'($urandom_range(0, 1));
            2: res_if.ready <= ~res_if.ready;
            default: res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // result monitor: values at the falling edge are those seen at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            model.check_result(res_if.data);
        end
    end

    function automatic t_in_item mk_item(t_kind k, int id, int x, int y, int z, int slot);
        t_in_item it;
        it.kind          = k;
        it.particle_id   = ID_W'(id);
        it.pos_x         = POS_W'(x);
        it.pos_y         = POS_W'(y);
        it.pos_z         = POS_W'(z);
        it.neighbor_slot = SLOT_W'(slot);
        return it;
    endfunction

    // position that usually bins inside the grid on one axis
    function automatic logic signed [POS_W-1:0] pick_pos(int a);
        int n;
        int span;
        int p;
        int c;
        n = model.axis_n(a);
        if (model.inv == 0) span = 65535;
        else span = (n * 65536) / int'(model.inv) + 1;
        if (span > 65535) span = 65535;
        repeat (16) begin
            p = int'(model.org[a]) + int'($urandom_range(0, span));
            if (p <= 32767 && model.axis_cell(a, POS_W'(p), c)) begin
                return POS_W'(p);
            end
        end
        return POS_W'($urandom);
    endfunction

    // random item: mostly inserts into the grid and queries of binned particles
    function automatic t_in_item rand_item();
        t_in_item it;
        int       r;
        it = mk_item(KIND_QUERY, int'($urandom), int'($urandom), int'($urandom),
                     int'($urandom), int'($urandom));
        r = $urandom_range(0, 99);
        if (r < 2) begin
            it.kind = KIND_CLEAR;
        end else if (r < 5) begin
            it.kind = KIND_NONE;
        end else if (r < 50) begin
            it.kind = KIND_INSERT;
            r = $urandom_range(0, 9);
            if (r < 6) it.particle_id = ID_W'($urandom_range(0, 31));
            else if (r == 9 && known_ids.size() != 0)
                it.particle_id = ID_W'(known_ids[$urandom_range(0, known_ids.size() - 1)]);
            if ($urandom_range(0, 6) != 0) begin
                it.pos_x = pick_pos(0);
                it.pos_y = pick_pos(1);
                it.pos_z = pick_pos(2);
            end
            known_ids.insert(known_ids.size(), int'(it.particle_id));
            if (known_ids.size() > 64) void'(known_ids.pop_front());
        end else begin
            if (known_ids.size() != 0 && $urandom_range(0, 6) != 0)
                it.particle_id = ID_W'(known_ids[$urandom_range(0, known_ids.size() - 1)]);
            if ($urandom_range(0, 9) == 0) it.neighbor_slot = SLOT_W'($urandom_range(27, 31));
            else it.neighbor_slot = SLOT_W'($urandom_range(0, 26));
        end
        return it;
    endfunction

    // one input transfer, sent in bursts with random gaps
    task automatic push_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        do @(negedge i_clk); while (item_if.ready !== 1'b1);
        model.note_item(it);
        items_sent++;
        @(posedge i_clk);
        burst_left--;
    endtask

    // wait for every expected result, then let the block go idle
    task automatic settle();
        item_if.valid <= 1'b0;
        while (model.pending_results.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(t_cfg_idx idx, int v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(v);
        @(posedge i_clk);
        model.set_reg(idx, CFG_W'(v));
    endtask

    task automatic run_random(int count);
        t_in_item it;
        int       done;
        done = 0;
        while (done < count) begin
            it = rand_item();
            push_item(it);
            if (t_kind'(it.kind) != KIND_NONE) done++;
        end
    endtask

    // new grid setting, a clear, then random traffic
    task automatic run_setting(int ox, int oy, int oz, int inv, int nx, int ny, int nz,
                               int count);
        settle();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_INV_CELL, inv);
        write_reg(CFG_CELLS_X, nx);
        write_reg(CFG_CELLS_Y, ny);
        write_reg(CFG_CELLS_Z, nz);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        known_ids.delete();
        settings_run++;
        push_item(mk_item(KIND_CLEAR, 0, 0, 0, 0, 0));
        run_random(count);
    endtask

    // run limit
    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        model         = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        item_if.valid = 1'b0;
        item_if.data  = '0;
        res_if.ready  = 1'b0;
        stall_mode    = 0;
        stall_timer   = 0;
        burst_left    = 0;
        items_sent    = 0;
        settings_run  = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items on the reset grid: cells 256 units wide from the origin
        push_item(mk_item(KIND_CLEAR, 0, 0, 0, 0, 0));
        push_item(mk_item(KIND_INSERT, 0, 0, 0, 0, 0));
        push_item(mk_item(KIND_INSERT, 4095, 4095, 4095, 4095, 31));
        push_item(mk_item(KIND_INSERT, 1, -1, 0, 0, 0));
        push_item(mk_item(KIND_INSERT, 2, 0, 32767, 0, 0));
        push_item(mk_item(KIND_INSERT, 3, 0, 0, -32768, 0));
        push_item(mk_item(KIND_INSERT, 4, 255, 0, 0, 0));
        push_item(mk_item(KIND_INSERT, 5, 256, 0, 0, 0));
        push_item(mk_item(KIND_QUERY, 0, 0, 0, 0, 13));
        push_item(mk_item(KIND_QUERY, 0, 0, 0, 0, 14));
        push_item(mk_item(KIND_QUERY, 0, 0, 0, 0, 0));
        push_item(mk_item(KIND_QUERY, 4095, -1, -1, -1, 26));
        push_item(mk_item(KIND_QUERY, 4095, 0, 0, 0, 13));
        // particle last binned outside, and one never binned
        push_item(mk_item(KIND_QUERY, 1, 0, 0, 0, 13));
        push_item(mk_item(KIND_QUERY, 77, 0, 0, 0, 13));
        // slot beyond the 27 neighbours, then an empty neighbour cell
        push_item(mk_item(KIND_QUERY, 5, 0, 0, 0, 31));
        push_item(mk_item(KIND_QUERY, 5, 0, 0, 0, 22));
        push_item(mk_item(KIND_NONE, 4095, -1, -1, -1, 31));
        // remembered cells survive a clear, their cells come back empty
        push_item(mk_item(KIND_CLEAR, 4095, -1, -1, -1, 31));
        push_item(mk_item(KIND_QUERY, 0, 0, 0, 0, 13));
        push_item(mk_item(KIND_QUERY, 4095, 0, 0, 0, 12));
        run_random(40);

        // single cell at the origin extremes, fills at once
        run_setting(-32768, 32767, 0, 65535, 0, 0, 0, 40);
        run_setting(-1000, 500, 0, 4096, 2, 3, 2, 70);
        // oversized counts clamp, tiny scale puts everything in one cell
        run_setting(-32768, -32768, -32768, 1, 31, 17, 16, 40);
        // zero scale: every product is zero
        run_setting(32767, 32767, 32767, 0, 4, 4, 4, 35);
        run_setting(-2048, -2048, -2048, 512, 16, 16, 16, 80);
        run_setting(100, -100, 0, 128, 1, 3, 5, 65);
        settle();

        $display("covered %0d items over %0d grid settings, %0d results checked",
            items_sent, settings_run, model.checked);
        $display("status ok %0d, outside %0d, full %0d, neighbour outside %0d, ids found %0d",
            model.status_seen[ST_OK], model.status_seen[ST_OUTSIDE], model.status_seen[ST_FULL],
            model.status_seen[ST_NBR_OUT], model.found_seen);
        if (model.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ uniform_grid_neighbor_binning.f @@
rtl/core/ugnb_pkg.sv
rtl/core/ugnb_in_if.sv
rtl/core/ugnb_out_if.sv
rtl/core/ugnb_ram.sv
rtl/core/ugnb_axis_lane.sv
rtl/core/uniform_grid_neighbor_binning.sv
verif/uniform_grid_neighbor_binning_tb.sv
